// ----- design/brf_pkg.sv -----
package brf_pkg;

  // Operation codes
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_SWITCH = 2'd2;

  // Processor mode codes
  localparam logic [4:0] MODE_USR  = 5'h10;
  localparam logic [4:0] MODE_FAST = 5'h11;
  localparam logic [4:0] MODE_INTR = 5'h12;
  localparam logic [4:0] MODE_SVC  = 5'h13;
  localparam logic [4:0] MODE_ABT  = 5'h17;
  localparam logic [4:0] MODE_UND  = 5'h1B;
  localparam logic [4:0] MODE_SYS  = 5'h1F;

  // Register file geometry
  localparam int NUM_REGS  = 16;
  localparam int BANK_BASE = 8;
  localparam int BANK_LEN  = 7;
  localparam int NUM_LINKS = 4;
  localparam logic [3:0] LINK_REG = 4'd14;

  // Request as held in the input register
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [4:0]  new_mode;
  } req_t;

  // Result of one request
  typedef struct packed {
    logic [31:0] read_data;
    logic        mode_error;
    logic [4:0]  cur_mode;
  } rsp_t;

  // Exception link slot lookup
  typedef struct packed {
    logic       hit;
    logic [1:0] slot;
  } link_sel_t;

  function automatic link_sel_t link_slot(input logic [4:0] m);
    link_sel_t s;
    s.hit  = 1'b1;
    s.slot = 2'd0;
    unique case (m)
      MODE_INTR: s.slot = 2'd0;
      MODE_SVC:  s.slot = 2'd1;
      MODE_ABT:  s.slot = 2'd2;
      MODE_UND:  s.slot = 2'd3;
      default:   s.hit  = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic is_user(input logic [4:0] m);
    return (m == MODE_USR) || (m == MODE_SYS);
  endfunction

  function automatic logic mode_known(input logic [4:0] m);
    link_sel_t s;
    s = link_slot(m);
    return is_user(m) || (m == MODE_FAST) || s.hit;
  endfunction

endpackage

// ----- design/brf_regfile.sv -----
module brf_regfile (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          exec_en,
  input  brf_pkg::req_t req,
  output brf_pkg::rsp_t rsp
);
  import brf_pkg::*;

  logic [31:0] live_r [NUM_REGS];
  logic [31:0] live_nxt [NUM_REGS];
  logic [31:0] usr_r [BANK_LEN];
  logic [31:0] usr_nxt [BANK_LEN];
  logic [31:0] fiq_r [BANK_LEN];
  logic [31:0] fiq_nxt [BANK_LEN];
  logic [31:0] lnk_r [NUM_LINKS];
  logic [31:0] lnk_nxt [NUM_LINKS];
  logic [4:0]  mode_r;
  logic [4:0]  mode_nxt;

  link_sel_t cur_sel;
  link_sel_t new_sel;

  assign cur_sel = link_slot(mode_r);
  assign new_sel = link_slot(req.new_mode);

  // Execute one request: save to the old bank first, then load from the new
  always_comb begin
    live_nxt       = live_r;
    usr_nxt        = usr_r;
    fiq_nxt        = fiq_r;
    lnk_nxt        = lnk_r;
    mode_nxt       = mode_r;
    rsp.read_data  = '0;
    rsp.mode_error = 1'b0;
    if (exec_en) begin
      unique case (req.op)
        OP_READ: begin
          rsp.read_data = live_r[req.idx];
        end
        OP_WRITE: begin
          live_nxt[req.idx] = req.val;
        end
        OP_SWITCH: begin
          if (mode_known(req.new_mode)) begin
            // save
            if (is_user(mode_r)) begin
              for (int i = 0; i < BANK_LEN; i++) usr_nxt[i] = live_r[4'(BANK_BASE + i)];
            end else if (mode_r == MODE_FAST) begin
              for (int i = 0; i < BANK_LEN; i++) fiq_nxt[i] = live_r[4'(BANK_BASE + i)];
            end else if (cur_sel.hit) begin
              lnk_nxt[cur_sel.slot] = live_r[LINK_REG];
            end
            // load
            if (is_user(req.new_mode)) begin
              for (int i = 0; i < BANK_LEN; i++) live_nxt[4'(BANK_BASE + i)] = usr_nxt[i];
            end else if (req.new_mode == MODE_FAST) begin
              for (int i = 0; i < BANK_LEN; i++) live_nxt[4'(BANK_BASE + i)] = fiq_nxt[i];
            end else if (new_sel.hit) begin
              live_nxt[LINK_REG] = lnk_nxt[new_sel.slot];
            end
            mode_nxt = req.new_mode;
          end else begin
            rsp.mode_error = 1'b1;
          end
        end
        default: ;
      endcase
    end
    rsp.cur_mode = mode_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) live_r[i] <= '0;
      for (int i = 0; i < BANK_LEN; i++) begin
        usr_r[i] <= '0;
        fiq_r[i] <= '0;
      end
      for (int i = 0; i < NUM_LINKS; i++) lnk_r[i] <= '0;
      mode_r <= MODE_SVC;
    end else begin
      live_r <= live_nxt;
      usr_r  <= usr_nxt;
      fiq_r  <= fiq_nxt;
      lnk_r  <= lnk_nxt;
      mode_r <= mode_nxt;
    end
  end

  // Rejected switch leaves the mode alone
  a_bad_switch_holds: assert property (@(posedge clk) disable iff (!rst_n)
    exec_en && req.op == OP_SWITCH && !mode_known(req.new_mode) |=> $stable(mode_r))
    else $error("mode changed on rejected switch");

  // Accepted switch takes the requested mode
  a_switch_mode: assert property (@(posedge clk) disable iff (!rst_n)
    exec_en && req.op == OP_SWITCH && mode_known(req.new_mode)
      |=> mode_r == $past(req.new_mode))
    else $error("mode not taken on switch");

  // Write lands in the addressed register
  a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    exec_en && req.op == OP_WRITE |=> live_r[$past(req.idx)] == $past(req.val))
    else $error("write lost");

endmodule

// ----- design/banked_register_file_top.sv -----
// Banked register file with processor-mode banking.
// Input channel (in_*): one request per transfer; in_tuser carries the
// operation (read, write, mode switch), in_tdata the register number, the
// write value and the new mode code.
// Result channel (out_*): exactly one result per request, in request order,
// carrying read data, an unknown-mode flag and the mode in force afterwards.
// A request is taken into the input register, executed from there into the
// result register, and its result is shown on out_tvalid from then on.
// Throughput: one request per cycle while the receiver takes results; the
// input register and the result register each hold one request, and the
// single execute stage between them updates all register state.
// When the receiver stalls the result register holds, the execute stage
// waits and the input register fills; in_tready drops only when both are full.
// Reset (synchronous, rst_n low) clears all registers and banks to zero,
// sets the mode to supervisor and empties both pipeline registers.
module banked_register_file_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // reg_index[3:0], write_value[35:4], new_mode[40:36], zeros
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // read_data[31:0], mode_error[32], current_mode_out[37:33], zeros
);
  import brf_pkg::*;

  logic  in_v_r;
  req_t  in_req_r;
  logic  out_v_r;
  rsp_t  out_rsp_r;
  logic  advance;
  rsp_t  rsp;

  // Execute when a request waits and the result register is free or being read out
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_req_r.op       <= in_tuser;
      in_req_r.idx      <= in_tdata[3:0];
      in_req_r.val      <= in_tdata[35:4];
      in_req_r.new_mode <= in_tdata[40:36];
    end
  end

  brf_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .exec_en (advance),
    .req     (in_req_r),
    .rsp     (rsp)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_rsp_r.cur_mode, out_rsp_r.mode_error, out_rsp_r.read_data};

endmodule

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brf_pkg::*;

  // Operation code 3 is unused by the block: it must change nothing
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int N_RANDOM   = 1250;
  localparam int CALM_TAIL  = 150;  // last random requests run without idling
  localparam int LONG_HOLD  = 64;   // cycles of the long receiver stall
  localparam int HOLD_AT    = 300;  // random request index that triggers it
  localparam int MAX_SHOWN  = 10;

  typedef struct {
    req_t r;
    bit   typed;  // expected result given in the table
    rsp_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // reg_index[3:0], write_value[35:4], new_mode[40:36], zeros
  logic [1:0]  in_tuser;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // read_data[31:0], mode_error[32], current_mode_out[37:33], zeros

  banked_register_file_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Architectural state as the predictor sees it
  logic [31:0] arch_regs [NUM_REGS];
  logic [31:0] usr_regs  [BANK_LEN];
  logic [31:0] fiq_regs  [BANK_LEN];
  logic [31:0] exc_lr    [NUM_LINKS];
  logic [4:0]  arch_mode;

  rsp_t      due_results [$];
  stim_row_t dir_rows [$];
  stim_row_t on_offer;   // request currently presented on the input

  bit calm;        // no idling on either side
  bit hold_long;   // asks the receiver for one long stall
  int err_cnt;
  int n_read, n_write, n_switch, n_bad_mode, n_nop, n_in_stall;

  // Link register slot of an exception mode, -1 for the others
  function automatic int link_idx(input logic [4:0] m);
    case (m)
      MODE_INTR: return 0;
      MODE_SVC:  return 1;
      MODE_ABT:  return 2;
      MODE_UND:  return 3;
      default:   return -1;
    endcase
  endfunction

  // Perform one access on the predictor state and return its result
  function automatic rsp_t apply_access(input req_t r);
    rsp_t o;
    int   s;
    int   i;
    o = '0;
    case (r.op)
      OP_READ:  o.read_data = arch_regs[r.idx];
      OP_WRITE: arch_regs[r.idx] = r.val;
      OP_SWITCH: begin
        if (r.new_mode == MODE_USR || r.new_mode == MODE_SYS || r.new_mode == MODE_FAST ||
            link_idx(r.new_mode) >= 0) begin
          // save what the outgoing mode banks
          s = link_idx(arch_mode);
          if (arch_mode == MODE_USR || arch_mode == MODE_SYS) begin
            for (i = 0; i < BANK_LEN; i++) usr_regs[i] = arch_regs[BANK_BASE + i];
          end else if (arch_mode == MODE_FAST) begin
            for (i = 0; i < BANK_LEN; i++) fiq_regs[i] = arch_regs[BANK_BASE + i];
          end else if (s >= 0) begin
            exc_lr[s] = arch_regs[LINK_REG];
          end
          // load what the incoming mode banks; the rest stays live
          s = link_idx(r.new_mode);
          if (r.new_mode == MODE_USR || r.new_mode == MODE_SYS) begin
            for (i = 0; i < BANK_LEN; i++) arch_regs[BANK_BASE + i] = usr_regs[i];
          end else if (r.new_mode == MODE_FAST) begin
            for (i = 0; i < BANK_LEN; i++) arch_regs[BANK_BASE + i] = fiq_regs[i];
          end else if (s >= 0) begin
            arch_regs[LINK_REG] = exc_lr[s];
          end
          arch_mode = r.new_mode;
        end else begin
          o.mode_error = 1'b1;
        end
      end
      default: ;
    endcase
    o.cur_mode = arch_mode;
    return o;
  endfunction

  // One line of the directed table
  task automatic row(input logic [1:0] op, input logic [3:0] idx, input logic [31:0] val,
                     input logic [4:0] nm, input bit typed, input logic [31:0] rd,
                     input logic err, input logic [4:0] md);
    stim_row_t t;
    t.r.op = op;
    t.r.idx = idx;
    t.r.val = val;
    t.r.new_mode = nm;
    t.typed = typed;
    t.want.read_data = rd;
    t.want.mode_error = err;
    t.want.cur_mode = md;
    dir_rows.push_back(t);
  endtask

  // Present one request, with an occasional idle burst first
  task automatic offer(input stim_row_t t);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    on_offer = t;
    in_tvalid <= 1'b1;
    in_tuser <= t.r.op;
    in_tdata <= {7'b0, t.r.new_mode, t.r.val, t.r.idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Monitor: predict on accepted requests, check accepted results
  rsp_t got, want, pred;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_tready) n_in_stall++;
      if (in_tvalid && in_tready) begin
        pred = apply_access(on_offer.r);
        due_results.push_back(on_offer.typed ? on_offer.want : pred);
        case (on_offer.r.op)
          OP_READ:   n_read++;
          OP_WRITE:  n_write++;
          OP_SWITCH: if (pred.mode_error) n_bad_mode++; else n_switch++;
          default:   n_nop++;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.read_data  = out_tdata[31:0];
        got.mode_error = out_tdata[32];
        got.cur_mode   = out_tdata[37:33];
        if (due_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("%0t: result with no request pending: data=%h err=%b mode=%h",
                     $realtime, got.read_data, got.mode_error, got.cur_mode);
        end else begin
          want = due_results.pop_front();
          if (got.read_data !== want.read_data || got.mode_error !== want.mode_error ||
              got.cur_mode !== want.cur_mode) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN)
              $display("%0t: mismatch: data exp %h got %h, err exp %b got %b, mode exp %h got %h",
                       $realtime, want.read_data, got.read_data, want.mode_error,
                       got.mode_error, want.cur_mode, got.cur_mode);
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    stim_row_t t;
    int        k;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    calm      = 1'b0;
    hold_long = 1'b0;
    err_cnt   = 0;
    for (k = 0; k < NUM_REGS; k++) arch_regs[k] = '0;
    for (k = 0; k < BANK_LEN; k++) begin
      usr_regs[k] = '0;
      fiq_regs[k] = '0;
    end
    for (k = 0; k < NUM_LINKS; k++) exc_lr[k] = '0;
    arch_mode = MODE_SVC;

    // Directed table: reset values, field extremes, every operation,
    // unknown modes, partial banking, switching to the mode already in force
    row(OP_READ,   4'd0,  32'h0,        5'h00,     1, 32'h0,        1'b0, MODE_SVC);
    row(OP_READ,   4'd15, 32'hFFFFFFFF, 5'h1F,     1, 32'h0,        1'b0, MODE_SVC);
    row(OP_WRITE,  4'd0,  32'hFFFFFFFF, 5'h1F,     1, 32'h0,        1'b0, MODE_SVC);
    row(OP_WRITE,  4'd15, 32'hA5A55A5A, 5'h00,     1, 32'h0,        1'b0, MODE_SVC);
    row(OP_READ,   4'd0,  32'h0,        5'h00,     1, 32'hFFFFFFFF, 1'b0, MODE_SVC);
    row(OP_WRITE,  4'd14, 32'h5555AAAA, 5'h00,     0, 32'h0,        1'b0, MODE_SVC);
    row(OP_WRITE,  4'd8,  32'h12345678, 5'h00,     0, 32'h0,        1'b0, MODE_SVC);
    row(OP_SWITCH, 4'd0,  32'h0,        5'h00,     1, 32'h0,        1'b1, MODE_SVC);
    row(OP_SWITCH, 4'd15, 32'hFFFFFFFF, 5'h1E,     1, 32'h0,        1'b1, MODE_SVC);
    row(OP_SWITCH, 4'd0,  32'h0,        MODE_FAST, 1, 32'h0,        1'b0, MODE_FAST);
    row(OP_READ,   4'd8,  32'h0,        5'h00,     0, 32'h0,        1'b0, MODE_FAST);
    row(OP_WRITE,  4'd8,  32'hDEADBEEF, 5'h00,     0, 32'h0,        1'b0, MODE_FAST);
    row(OP_WRITE,  4'd14, 32'hCAFEF00D, 5'h00,     0, 32'h0,        1'b0, MODE_FAST);
    row(OP_SWITCH, 4'd0,  32'h0,        MODE_INTR, 0, 32'h0,        1'b0, MODE_INTR);
    row(OP_READ,   4'd8,  32'h0,        5'h00,     0, 32'h0,        1'b0, MODE_INTR);
    row(OP_READ,   4'd14, 32'h0,        5'h00,     0, 32'h0,        1'b0, MODE_INTR);
    row(OP_SWITCH, 4'd0,  32'h0,        MODE_SVC,  0, 32'h0,        1'b0, MODE_SVC);
    row(OP_READ,   4'd14, 32'h0,        5'h00,     0, 32'h0,        1'b0, MODE_SVC);
    row(OP_SWITCH, 4'd0,  32'h0,        MODE_USR,  0, 32'h0,        1'b0, MODE_USR);
    row(OP_READ,   4'd8,  32'h0,        5'h00,     0, 32'h0,        1'b0, MODE_USR);
    row(OP_SWITCH, 4'd0,  32'h0,        MODE_SYS,  0, 32'h0,        1'b0, MODE_SYS);
    row(OP_SWITCH, 4'd0,  32'h0,        MODE_SYS,  0, 32'h0,        1'b0, MODE_SYS);
    row(OP_SWITCH, 4'd0,  32'h0,        MODE_ABT,  0, 32'h0,        1'b0, MODE_ABT);
    row(OP_SWITCH, 4'd0,  32'h0,        MODE_UND,  0, 32'h0,        1'b0, MODE_UND);
    row(OP_NONE,   4'd15, 32'hFFFFFFFF, 5'h1F,     0, 32'h0,        1'b0, MODE_UND);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[j]) offer(dir_rows[j]);

    // Random accesses, mostly reads and writes, with mode switches to mostly known modes
    t.typed = 1'b0;
    t.want  = '0;
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == HOLD_AT) hold_long = 1'b1;
      calm = (k >= N_RANDOM - CALM_TAIL);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: t.r.op = OP_READ;
        8, 9, 10, 11, 12, 13:   t.r.op = OP_WRITE;
        19:                     t.r.op = OP_NONE;
        default:                t.r.op = OP_SWITCH;
      endcase
      t.r.idx = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 7))
        0:       t.r.val = 32'h0;
        1:       t.r.val = 32'hFFFFFFFF;
        default: t.r.val = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       t.r.new_mode = MODE_USR;
        1:       t.r.new_mode = MODE_FAST;
        2:       t.r.new_mode = MODE_INTR;
        3:       t.r.new_mode = MODE_SVC;
        4:       t.r.new_mode = MODE_ABT;
        5:       t.r.new_mode = MODE_UND;
        6, 7:    t.r.new_mode = MODE_SYS;
        default: t.r.new_mode = 5'($urandom_range(0, 31));
      endcase
      offer(t);
    end
    in_tvalid <= 1'b0;

    // Drain until every expected result has been checked, then idle
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d reads, %0d writes, %0d mode switches, %0d unknown mode codes,",
             n_read, n_write, n_switch, n_bad_mode);
    $display("%0d unused operations, %0d cycles with the input held off by back-pressure",
             n_nop, n_in_stall);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", err_cnt);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/brf_pkg.sv
design/brf_regfile.sv
design/banked_register_file_top.sv
sim/tb.sv
